// ===== rtl/fimu_pkg.sv =====
// ----------------------------------------------------------------------------
// fimu_pkg: shared types and constants for the flow/IMU odometry block
// Command and status structs, fixed-point constants and the arctangent table.
// ----------------------------------------------------------------------------
package fimu_pkg;

  localparam int POS_WIDTH_DEF    = 48;
  localparam int ROTATE_STEPS_DEF = 16;

  localparam int IDX_W    = 5;   // rotation step index, table holds 24 entries
  localparam int DIVD_W   = 48;  // |value| * ms + 500
  localparam int DQ_W     = 40;  // signed scaled result

  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
  localparam logic [9:0]  MS_PER_S    = 10'd1000;

  // divide by 1000: estimate from the top 32 dividend bits, then fix up the
  // remainder (below 2^18) with a short reciprocal that is exact there
  localparam logic [31:0] DIV_RECIP    = 32'd2199023255;  // floor(2^41 / 1000)
  localparam int          DIV_RECIP_SH = 25;
  localparam logic [18:0] REM_RECIP    = 19'd268436;      // ceil(2^28 / 1000)
  localparam int          REM_RECIP_SH = 28;

  // configuration register indexes
  localparam logic CFG_BLEND  = 1'b0;
  localparam logic CFG_OFFSET = 1'b1;

  // scale operand select
  localparam logic [1:0] SEL_ACC = 2'd0;
  localparam logic [1:0] SEL_ROT = 2'd1;
  localparam logic [1:0] SEL_VEL = 2'd2;

  typedef struct packed {
    logic             load;
    logic             rot_step;
    logic [IDX_W-1:0] rot_idx;
    logic             gain_mul;
    logic             gain_fin;
    logic [1:0]       sc_sel;
    logic             sc_mul;
    logic             div_start;
    logic             pred;
    logic             blend_mul;
    logic             blend_fin;
    logic             pos_upd;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic div_done;
    logic out_busy;
  } sts_t;

  function automatic logic [31:0] atan_lut(input logic [IDX_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647)       r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/flow_imu_complementary_odometry.sv =====
// ----------------------------------------------------------------------------
// flow_imu_complementary_odometry: planar flow/IMU odometry, fixed point
// Rotates flow velocity into the world frame and integrates position.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one transaction per sensor update
//   carrying opcode, flow velocity, heading, acceleration and elapsed ms.
//   Result channel (out_valid / out_stall): one transaction per input with
//   the updated position and stored velocity.
//   Config port: cfg_wr_en writes cfg_data to register cfg_index
//   (0 blend weight, 1 mount angle offset). Write only while idle.
// Timing
//   One transaction at a time; in_stall is high while one is being worked.
//   The sequencer returns to idle after loading each result and only then
//   takes the next transaction. Each transaction runs the CORDIC iterations
//   and the reciprocal divide by 1000 (once flow-only, twice fused).
// Reset
//   Synchronous, active low: velocity and position clear, blend weight
//   returns to one half and the offset to zero; no result is pending.
// Stall
//   A result sits in the output register until taken; the next input is
//   worked meanwhile and waits only at write-back for the register to free.
// ----------------------------------------------------------------------------
module flow_imu_complementary_odometry #(
  parameter int POS_WIDTH    = fimu_pkg::POS_WIDTH_DEF,
  parameter int ROTATE_STEPS = fimu_pkg::ROTATE_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [16:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic signed [31:0]          in_flow_vel_x,
  input  logic signed [31:0]          in_flow_vel_y,
  input  logic [15:0]                 in_heading,
  input  logic signed [31:0]          in_accel_x,
  input  logic signed [31:0]          in_accel_y,
  input  logic [15:0]                 in_elapsed_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [POS_WIDTH-1:0] out_pos_x,
  output logic signed [POS_WIDTH-1:0] out_pos_y,
  output logic signed [31:0]          out_vel_x,
  output logic signed [31:0]          out_vel_y
);
  import fimu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per datapath operation
  fimu_ctrl #(.ROT_N(ROTATE_STEPS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .cmd, .sts
  );

  // datapath: CORDIC, shared-by-lane multipliers, dividers, state registers
  fimu_dp #(.POS_W(POS_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_wr_en, .cfg_index, .cfg_data,
    .in_opcode, .in_flow_vel_x, .in_flow_vel_y, .in_heading,
    .in_accel_x, .in_accel_y, .in_elapsed_ms,
    .out_stall, .out_valid, .out_pos_x, .out_pos_y, .out_vel_x, .out_vel_y
  );

`ifndef SYNTHESIS
  // an accepted transaction keeps the input side busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // a new result only appears while a transaction is being worked
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without transaction in progress");

  // a stalled result is not dropped
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result lost");
`endif

endmodule

// ===== rtl/fimu_div.sv =====
// ----------------------------------------------------------------------------
// fimu_div: divider by 1000, reciprocal multiplication
// Three stages: estimate, remainder, correction; done pulses with the result.
// ----------------------------------------------------------------------------
module fimu_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [fimu_pkg::DIVD_W-1:0]    dividend,
  output logic [fimu_pkg::DIVD_W-1:0]    quotient,
  output logic                           done
);
  import fimu_pkg::*;

  logic [63:0]       prod_r;
  logic [DIVD_W-1:0] n_r;
  logic [DIVD_W-1:0] qe_r;
  logic [17:0]       rem_r;
  logic [DIVD_W-1:0] q_r;
  logic              s1_r, s2_r, done_r;
  logic [DIVD_W-1:0] est, back;
  logic [36:0]       fix;

  // estimate never exceeds the true quotient and falls short by under 195
  always_comb begin
    est  = DIVD_W'(prod_r >> DIV_RECIP_SH);
    back = est * DIVD_W'(MS_PER_S);
    fix  = rem_r * REM_RECIP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      done_r <= s2_r;
    end
    if (start) begin
      prod_r <= 64'(dividend[DIVD_W-1:16]) * 64'(DIV_RECIP);
      n_r    <= dividend;
    end
    if (s1_r) begin
      qe_r  <= est;
      rem_r <= 18'(n_r - back);
    end
    if (s2_r) q_r <= qe_r + DIVD_W'(fix >> REM_RECIP_SH);
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

// ===== rtl/fimu_dp.sv =====
// ----------------------------------------------------------------------------
// fimu_dp: odometry datapath
// Rotation, gain removal, dt scaling, blend, position accumulation, result reg.
// ----------------------------------------------------------------------------
module fimu_dp #(
  parameter int POS_W = fimu_pkg::POS_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fimu_pkg::cmd_t           cmd,
  output fimu_pkg::sts_t           sts,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_index,
  input  logic [16:0]              cfg_data,
  input  logic                     in_opcode,
  input  logic signed [31:0]       in_flow_vel_x,
  input  logic signed [31:0]       in_flow_vel_y,
  input  logic [15:0]              in_heading,
  input  logic signed [31:0]       in_accel_x,
  input  logic signed [31:0]       in_accel_y,
  input  logic [15:0]              in_elapsed_ms,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [POS_W-1:0]  out_pos_x,
  output logic signed [POS_W-1:0]  out_pos_y,
  output logic signed [31:0]       out_vel_x,
  output logic signed [31:0]       out_vel_y
);
  import fimu_pkg::*;

  localparam int SW = ((POS_W > DQ_W) ? POS_W : DQ_W) + 1;
  localparam logic signed [SW-1:0] PMAX = SW'($signed({1'b0, {(POS_W-1){1'b1}}}));
  localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);
  localparam logic signed [30:0]   GAIN_S = $signed({1'b0, CORDIC_GAIN});

  logic [16:0] bw_r;
  logic [15:0] off_r;
  logic        op_r;
  logic signed [31:0] ax_r, ay_r;
  logic [15:0] ms_r;
  logic signed [34:0] cx_r, cy_r;
  logic signed [31:0] z_r;
  logic signed [65:0] gx_r, gy_r;
  logic signed [31:0] rx_r, ry_r;
  logic        negx_r, negy_r;
  logic [DIVD_W-1:0] smx_r, smy_r;
  logic signed [40:0] prx_r, pry_r;
  logic signed [49:0] pax_r, pay_r;
  logic signed [58:0] pbx_r, pby_r;
  logic signed [31:0] vx_r, vy_r;
  logic signed [POS_W-1:0] px_r, py_r;
  logic        ov_r;
  logic signed [POS_W-1:0] opx_r, opy_r;
  logic signed [31:0] ovx_r, ovy_r;

  logic [15:0] ang;
  logic signed [34:0] fx35, fy35, dx, dy;
  logic signed [31:0] svx, svy;
  logic [31:0] magx, magy;
  logic [DIVD_W-1:0] qx, qy;
  logic        dnx, dny;
  logic signed [DQ_W-1:0] dqx, dqy;
  logic [16:0] alpha, beta;
  logic signed [59:0] bsx, bsy;
  logic signed [SW-1:0] sumx, sumy;

  fimu_div u_divx (.clk, .rst_n, .start(cmd.div_start), .dividend(smx_r),
                   .quotient(qx), .done(dnx));
  fimu_div u_divy (.clk, .rst_n, .start(cmd.div_start), .dividend(smy_r),
                   .quotient(qy), .done(dny));

  always_comb begin
    ang  = in_heading + off_r;
    fx35 = 35'(in_flow_vel_x);
    fy35 = 35'(in_flow_vel_y);
    dx   = cy_r >>> cmd.rot_idx;
    dy   = cx_r >>> cmd.rot_idx;
    case (cmd.sc_sel)
      SEL_ACC: begin svx = ax_r; svy = ay_r; end
      SEL_VEL: begin svx = vx_r; svy = vy_r; end
      default: begin svx = rx_r; svy = ry_r; end
    endcase
    magx  = svx[31] ? 32'(-svx) : 32'(svx);
    magy  = svy[31] ? 32'(-svy) : 32'(svy);
    dqx   = negx_r ? -$signed({1'b0, qx[DQ_W-2:0]}) : $signed({1'b0, qx[DQ_W-2:0]});
    dqy   = negy_r ? -$signed({1'b0, qy[DQ_W-2:0]}) : $signed({1'b0, qy[DQ_W-2:0]});
    alpha = (bw_r > 17'd65536) ? 17'd65536 : bw_r;
    beta  = 17'd65536 - alpha;
    bsx   = 60'(pax_r) + 60'(pbx_r) + 60'sd32768;
    bsy   = 60'(pay_r) + 60'(pby_r) + 60'sd32768;
    sumx  = SW'(px_r) + SW'(dqx);
    sumy  = SW'(py_r) + SW'(dqy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_r  <= 17'd32768;
      off_r <= '0;
      vx_r  <= '0;
      vy_r  <= '0;
      px_r  <= '0;
      py_r  <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_BLEND) bw_r  <= cfg_data;
        else                        off_r <= cfg_data[15:0];
      end
      if (cmd.blend_fin) begin
        vx_r <= sat32(66'(bsx >>> 16));
        vy_r <= sat32(66'(bsy >>> 16));
      end
      if (cmd.pos_upd) begin
        px_r <= (sumx > PMAX) ? PMAX[POS_W-1:0] :
                (sumx < PMIN) ? PMIN[POS_W-1:0] : sumx[POS_W-1:0];
        py_r <= (sumy > PMAX) ? PMAX[POS_W-1:0] :
                (sumy < PMIN) ? PMIN[POS_W-1:0] : sumy[POS_W-1:0];
      end
      if (cmd.out_load)          ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      ms_r <= in_elapsed_ms;
      z_r  <= $signed({2'b00, ang[13:0], 16'h0000});
      case (ang[15:14])
        2'd0:    begin cx_r <= fx35;  cy_r <= fy35;  end
        2'd1:    begin cx_r <= -fy35; cy_r <= fx35;  end
        2'd2:    begin cx_r <= -fx35; cy_r <= -fy35; end
        default: begin cx_r <= fy35;  cy_r <= -fx35; end
      endcase
    end else if (cmd.rot_step) begin
      if (!z_r[31]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - $signed(atan_lut(cmd.rot_idx));
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + $signed(atan_lut(cmd.rot_idx));
      end
    end
    if (cmd.gain_mul) begin
      gx_r <= cx_r * GAIN_S;
      gy_r <= cy_r * GAIN_S;
    end
    if (cmd.gain_fin) begin
      rx_r <= sat32((gx_r + (66'sd1 <<< 29)) >>> 30);
      ry_r <= sat32((gy_r + (66'sd1 <<< 29)) >>> 30);
    end
    if (cmd.sc_mul) begin
      negx_r <= svx[31];
      negy_r <= svy[31];
      smx_r  <= DIVD_W'(magx) * DIVD_W'(ms_r) + DIVD_W'(500);
      smy_r  <= DIVD_W'(magy) * DIVD_W'(ms_r) + DIVD_W'(500);
    end
    if (cmd.pred) begin
      prx_r <= 41'(vx_r) + 41'(dqx);
      pry_r <= 41'(vy_r) + 41'(dqy);
    end
    if (cmd.blend_mul) begin
      pax_r <= $signed({1'b0, alpha}) * rx_r;
      pay_r <= $signed({1'b0, alpha}) * ry_r;
      pbx_r <= $signed({1'b0, beta}) * prx_r;
      pby_r <= $signed({1'b0, beta}) * pry_r;
    end
    if (cmd.out_load) begin
      opx_r <= px_r;
      opy_r <= py_r;
      ovx_r <= vx_r;
      ovy_r <= vy_r;
    end
  end

  assign sts.op       = op_r;
  assign sts.div_done = dnx & dny;
  assign sts.out_busy = ov_r & out_stall;

  assign out_valid = ov_r;
  assign out_pos_x = opx_r;
  assign out_pos_y = opy_r;
  assign out_vel_x = ovx_r;
  assign out_vel_y = ovy_r;

endmodule

// ===== rtl/fimu_ctrl.sv =====
// ----------------------------------------------------------------------------
// fimu_ctrl: sequencer for the odometry datapath
// Steps one transaction through rotation, scaling, blend and position update.
// ----------------------------------------------------------------------------
module fimu_ctrl #(
  parameter int ROT_N = fimu_pkg::ROTATE_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output fimu_pkg::cmd_t  cmd,
  input  fimu_pkg::sts_t  sts
);
  import fimu_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROT  = 4'd1;
  localparam logic [3:0] S_GMUL = 4'd2;
  localparam logic [3:0] S_GFIN = 4'd3;
  localparam logic [3:0] S_SMUL = 4'd4;
  localparam logic [3:0] S_DST  = 4'd5;
  localparam logic [3:0] S_DWT  = 4'd6;
  localparam logic [3:0] S_PRED = 4'd7;
  localparam logic [3:0] S_BMUL = 4'd8;
  localparam logic [3:0] S_BFIN = 4'd9;
  localparam logic [3:0] S_POS  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       sel_r, sel_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.rot_idx = cnt_r;
    cmd.sc_sel  = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(ROT_N - 1)) state_nxt = S_GMUL;
      end
      S_GMUL: begin
        cmd.gain_mul = 1'b1;
        state_nxt    = S_GFIN;
      end
      S_GFIN: begin
        cmd.gain_fin = 1'b1;
        sel_nxt      = sts.op ? SEL_ACC : SEL_ROT;
        state_nxt    = S_SMUL;
      end
      S_SMUL: begin
        cmd.sc_mul = 1'b1;
        state_nxt  = S_DST;
      end
      S_DST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWT;
      end
      S_DWT: begin
        if (sts.div_done) state_nxt = (sel_r == SEL_ACC) ? S_PRED : S_POS;
      end
      S_PRED: begin
        cmd.pred  = 1'b1;
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        cmd.blend_mul = 1'b1;
        state_nxt     = S_BFIN;
      end
      S_BFIN: begin
        cmd.blend_fin = 1'b1;
        sel_nxt       = SEL_VEL;
        state_nxt     = S_SMUL;
      end
      S_POS: begin
        cmd.pos_upd = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= SEL_ROT;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== test/tb_flow_imu_complementary_odometry.sv =====
// ----------------------------------------------------------------------------
// tb_flow_imu_complementary_odometry: self-checking bench for the odometry block
// Drives flow/IMU updates with random idling on both sides, predicts position
// and velocity with its own fixed-point model, and checks every result.
// ----------------------------------------------------------------------------
module tb_flow_imu_complementary_odometry;
  import fimu_pkg::*;

  localparam int PW       = 48;
  localparam int STEPS    = 16;
  localparam int LATENCY  = STEPS + 120;
  localparam longint LIMIT = 3000000;

  typedef struct {
    logic               opcode;
    logic signed [31:0] fvx, fvy;
    logic [15:0]        heading;
    logic signed [31:0] ax, ay;
    logic [15:0]        ms;
  } update_t;

  typedef struct {
    logic signed [PW-1:0] px, py;
    logic signed [31:0]   vx, vy;
  } odo_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = CFG_BLEND;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic signed [31:0] in_flow_vel_x = '0, in_flow_vel_y = '0;
  logic [15:0] in_heading = '0;
  logic signed [31:0] in_accel_x = '0, in_accel_y = '0;
  logic [15:0] in_elapsed_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PW-1:0] out_pos_x, out_pos_y;
  logic signed [31:0] out_vel_x, out_vel_y;

  flow_imu_complementary_odometry #(.POS_WIDTH(PW), .ROTATE_STEPS(STEPS)) uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state and register copies
  longint vel_x_q, vel_y_q, pos_x_q, pos_y_q;
  int unsigned alpha_q, offset_q;

  update_t pending_updates[$];
  odo_t    expected_odo[$];
  int      errors = 0;
  longint  cycles = 0;
  bit      quiet = 1'b0;   // no idling in the closing stretch
  bit      hold_in = 1'b0; // sender paused by the stimulus thread
  int      in_gap = 0, out_gap = 0;

  // floor shift that is safe on negative values
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // v * ms / 1000, nearest, ties away from zero
  function automatic longint dt_scale(longint v, int unsigned ms);
    longint unsigned mag, q;
    mag = (v < 0) ? -v : v;
    q = (mag * ms + 500) / 1000;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint pos_accum(longint p, longint d);
    longint hi, lo;
    hi = (64'sd1 <<< (PW - 1)) - 1;
    lo = -hi - 1;
    if (d > 0 && p > hi - d) return hi;
    if (d < 0 && p < lo - d) return lo;
    return p + d;
  endfunction

  function automatic longint atan_turns(int i);
    case (i)
      0: return 64'h20000000;  1: return 64'h12E4051E;  2: return 64'h09FB385B;
      3: return 64'h051111D4;  4: return 64'h028B0D43;  5: return 64'h0145D7E1;
      6: return 64'h00A2F61E;  7: return 64'h00517C55;  8: return 64'h0028BE53;
      9: return 64'h00145F2F;  10: return 64'h000A2F98; 11: return 64'h000517CC;
      12: return 64'h00028BE6; 13: return 64'h000145F3; 14: return 64'h0000A2F9;
      15: return 64'h0000517C; 16: return 64'h000028BE; 17: return 64'h0000145F;
      18: return 64'h00000A2F; 19: return 64'h00000517; 20: return 64'h0000028B;
      21: return 64'h00000145; 22: return 64'h000000A2; default: return 64'h00000051;
    endcase
  endfunction

  // quarter turns exactly, then CORDIC on the residue, then gain removal
  task automatic rotate_flow(inout longint x, inout longint y, input int unsigned ang);
    longint t, z, dx, dy;
    for (int i = 0; i < ((ang >> 14) & 3); i++) begin
      t = x; x = -y; y = t;
    end
    z = longint'(ang & 16'h3FFF) * 65536;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turns(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turns(i));
      end
    end
    x = clip32(fshr(x * 652032874 + (64'sd1 <<< 29), 30));
    y = clip32(fshr(y * 652032874 + (64'sd1 <<< 29), 30));
  endtask

  // advance the predictor by one accepted update
  task automatic odometry_step(input update_t u);
    longint fx, fy, a, prx, pry;
    odo_t r;
    fx = u.fvx;
    fy = u.fvy;
    rotate_flow(fx, fy, (u.heading + offset_q) & 16'hFFFF);
    if (u.opcode) begin
      a = (alpha_q > 65536) ? 65536 : alpha_q;
      prx = vel_x_q + dt_scale(u.ax, u.ms);
      pry = vel_y_q + dt_scale(u.ay, u.ms);
      vel_x_q = clip32(fshr(a * fx + (65536 - a) * prx + 32768, 16));
      vel_y_q = clip32(fshr(a * fy + (65536 - a) * pry + 32768, 16));
      pos_x_q = pos_accum(pos_x_q, dt_scale(vel_x_q, u.ms));
      pos_y_q = pos_accum(pos_y_q, dt_scale(vel_y_q, u.ms));
    end else begin
      pos_x_q = pos_accum(pos_x_q, dt_scale(fx, u.ms));
      pos_y_q = pos_accum(pos_y_q, dt_scale(fy, u.ms));
    end
    r.px = pos_x_q[PW-1:0];
    r.py = pos_y_q[PW-1:0];
    r.vx = vel_x_q[31:0];
    r.vy = vel_y_q[31:0];
    expected_odo.push_back(r);
  endtask

  // driver: presents the head of the queue; a valid only drops after acceptance
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        update_t u;
        u = pending_updates.pop_front();
        odometry_step(u);
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        in_gap <= $urandom_range(0, 12);
      end else if (pending_updates.size() > (in_valid && !in_stall ? 0 : 0) &&
                   !hold_in && pending_updates.size() != 0) begin
        in_valid      <= 1'b1;
        in_opcode     <= pending_updates[0].opcode;
        in_flow_vel_x <= pending_updates[0].fvx;
        in_flow_vel_y <= pending_updates[0].fvy;
        in_heading    <= pending_updates[0].heading;
        in_accel_x    <= pending_updates[0].ax;
        in_accel_y    <= pending_updates[0].ay;
        in_elapsed_ms <= pending_updates[0].ms;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver idling
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_odo.size() == 0) begin
          $display("%0t: result with nothing expected: pos %0d,%0d vel %0d,%0d",
                   $time, out_pos_x, out_pos_y, out_vel_x, out_vel_y);
          errors = errors + 1;
        end else begin
          odo_t e;
          e = expected_odo.pop_front();
          if (out_pos_x !== e.px) begin
            $display("%0t: pos_x expected %0d actual %0d", $time, e.px, out_pos_x);
            errors = errors + 1;
          end
          if (out_pos_y !== e.py) begin
            $display("%0t: pos_y expected %0d actual %0d", $time, e.py, out_pos_y);
            errors = errors + 1;
          end
          if (out_vel_x !== e.vx) begin
            $display("%0t: vel_x expected %0d actual %0d", $time, e.vx, out_vel_x);
            errors = errors + 1;
          end
          if (out_vel_y !== e.vy) begin
            $display("%0t: vel_y expected %0d actual %0d", $time, e.vy, out_vel_y);
            errors = errors + 1;
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        out_gap <= $urandom_range(0, 12);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2, 3: return $urandom_range(0, 20 * 65536) - 10 * 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic update_t rand_update();
    update_t u;
    u.opcode  = 1'($urandom_range(0, 1));
    u.fvx     = rand_q16();
    u.fvy     = rand_q16();
    u.heading = 16'($urandom);
    u.ax      = rand_q16();
    u.ay      = rand_q16();
    case ($urandom_range(0, 5))
      0: u.ms = 16'hFFFF;
      1: u.ms = 16'd0;
      default: u.ms = 16'($urandom_range(1, 50));
    endcase
    return u;
  endfunction

  task automatic add_update(input logic op, input logic [31:0] fx, fy,
                            input logic [15:0] hd, input logic [31:0] ax, ay,
                            input logic [15:0] ms);
    update_t u;
    u.opcode = op; u.fvx = fx; u.fvy = fy; u.heading = hd;
    u.ax = ax; u.ay = ay; u.ms = ms;
    pending_updates.push_back(u);
  endtask

  // wait for the block to drain fully, then let its pipeline settle
  task automatic drain();
    while (pending_updates.size() != 0 || in_valid || expected_odo.size() != 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [16:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_BLEND) alpha_q = val;
    else offset_q = val[15:0];
  endtask

  initial begin
    vel_x_q = 0; vel_y_q = 0; pos_x_q = 0; pos_y_q = 0;
    alpha_q = 32768; offset_q = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, quarter turns, extremes, zero dt, both modes
    add_update(1'b0, 32'h00010000, 32'h00000000, 16'h0000, 0, 0, 16'd1000);
    add_update(1'b0, 32'h00010000, 32'h00000000, 16'h4000, 0, 0, 16'd1000);
    add_update(1'b0, 32'h00010000, 32'h00020000, 16'h8000, 0, 0, 16'd500);
    add_update(1'b0, 32'h00010000, 32'h00020000, 16'hC000, 0, 0, 16'd1);
    add_update(1'b0, 32'h7FFFFFFF, 32'h80000000, 16'h2000, 0, 0, 16'hFFFF);
    add_update(1'b0, 32'h80000000, 32'h80000000, 16'hFFFF, 0, 0, 16'hFFFF);
    add_update(1'b1, 32'h00010000, 32'hFFFF0000, 16'h1234, 32'h7FFFFFFF, 32'h80000000,
               16'd0);
    add_update(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h3FFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               16'hFFFF);
    add_update(1'b1, 32'h80000000, 32'h80000000, 16'hBFFF, 32'h80000000, 32'h80000000,
               16'hFFFF);
    add_update(1'b0, 32'h00000000, 32'h00000000, 16'h0000, 32'hFFFFFFFF, 32'hFFFFFFFF,
               16'd0);
    // push position up with repeated large positive steps
    for (int i = 0; i < 8; i++)
      add_update(1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h1000, 0, 0, 16'hFFFF);
    drain();

    // pure flow, then blend weight above one (treated as pure flow), odd offset
    write_reg(CFG_BLEND, 17'd65536);
    write_reg(CFG_OFFSET, 16'hFFFF);
    for (int i = 0; i < 4; i++) pending_updates.push_back(rand_update());
    add_update(1'b1, 32'h80000000, 32'h80000000, 16'h0001, 0, 0, 16'hFFFF);
    drain();
    write_reg(CFG_BLEND, 17'h1FFFF);
    write_reg(CFG_OFFSET, 16'h4000);
    for (int i = 0; i < 4; i++) pending_updates.push_back(rand_update());
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(CFG_BLEND, 17'd0);
        1: write_reg(CFG_BLEND, 17'd65535);
        default: write_reg(CFG_BLEND, 17'($urandom_range(0, 17'h1FFFF)));
      endcase
      write_reg(CFG_OFFSET, (ph == 0) ? 16'h0000 : 16'($urandom));
      for (int i = 0; i < 290; i++) pending_updates.push_back(rand_update());
      if (ph == 2) begin
        // sender holds off until every outstanding result is back
        while (pending_updates.size() > 150) @(posedge clk);
        hold_in = 1'b1;
        while (in_valid || expected_odo.size() != 0) @(posedge clk);
        hold_in = 1'b0;
      end
      if (ph == 5) quiet = 1'b1;
      drain();
    end

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fimu_pkg.sv
rtl/fimu_div.sv
rtl/fimu_dp.sv
rtl/fimu_ctrl.sv
rtl/flow_imu_complementary_odometry.sv
test/tb_flow_imu_complementary_odometry.sv
